[rtl/core/npva_pkg.sv]
// Package with shared types and constants of the note priority voice allocator.
package npva_pkg;

  localparam int MaxHeld = 256;
  localparam int MaxVoices = 16;
  localparam int HeldAw = $clog2(MaxHeld);
  localparam int CntW = $clog2(MaxHeld + 1);
  localparam int VoiceW = $clog2(MaxVoices);
  localparam int VcntW = $clog2(MaxVoices + 1);

  localparam logic [2:0] ModeLow = 3'd0;
  localparam logic [2:0] ModeHigh = 3'd1;
  localparam logic [2:0] ModeFirst = 3'd2;
  localparam logic [2:0] ModeLast = 3'd3;

  localparam logic RegMode = 1'b0;
  localparam logic RegVoices = 1'b1;

  typedef struct packed {
    logic [6:0] key;
    logic       pressed;
  } npva_in_t;

  typedef struct packed {
    logic [3:0] voice;
    logic [6:0] voice_key;
    logic       gate;
    logic       dropped;
    logic       last;
  } npva_out_t;

  typedef struct packed {
    logic [HeldAw-1:0] addr;
    logic [6:0]        key;
    logic [VoiceW-1:0] voice;
    logic              has;
  } npva_wr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_SEARCH_WAIT,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_STEAL_RD,
    S_STEAL_WR,
    S_STEAL_CLR,
    S_HAND_RD,
    S_HAND_WR,
    S_SCAN_RD,
    S_SCAN_WR,
    S_FREE,
    S_REPORT
  } npva_state_t;

endpackage

[rtl/core/note_priority_voice_allocator_core.sv]
// Top level of the note priority voice allocator.
//
// A key event is given on start with the request on req (key, pressed) and
// is taken when start is high and busy is low. The block then works on the
// event alone with busy high: a sequencer walks the held list memory one
// entry per step through a single key compare unit, to find the place of
// the key, to shift entries up or down, and to collect voice assignments.
// Each event is done in passes over the list: one to find the place and move
// the list, one to collect voices, each with a read step and a second step
// per entry; the single read port of the list memory sets this pace. The
// next request is taken in the cycle of the last result.
// After each event, one result per voice 0..voice_count-1 is shown on rsp,
// one per cycle, with rsp_valid high for that cycle; last marks the final
// one. The receiver cannot stall and must take each result as it comes.
// Configuration writes use cfg_valid/cfg_ready with cfg_index/cfg_data and
// are taken while idle. Writing voice_count empties the list and refills the
// free voice stack. Reset gives last note priority, one voice, an empty
// list, all gates off, all voice keys zero. There is no clearing pass.
module note_priority_voice_allocator_core
  import npva_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  npva_in_t   req,
  output logic       rsp_valid,
  output npva_out_t  rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data
);

  npva_state_t state, state_next;
  logic [2:0]        mode;
  logic [VcntW-1:0]  nv;
  logic [CntW-1:0]   held_count;
  logic [VcntW-1:0]  playing;
  logic [VoiceW-1:0] free_stack [MaxVoices];
  logic [6:0]        voice_keys [MaxVoices];
  logic              voice_gates [MaxVoices];
  logic [6:0]        key;
  logic              pressed;
  logic              dropped;
  logic [CntW-1:0]   idx;
  logic [CntW-1:0]   pos;
  logic [CntW-1:0]   n_old;
  logic              had;
  logic [VoiceW-1:0] fv;
  logic [VoiceW-1:0] new_voice;
  logic              new_has;
  logic              we;
  npva_wr_t          wr;
  logic [HeldAw-1:0] raddr;
  logic [6:0]        rkey;
  logic [VoiceW-1:0] rvoice;
  logic              rhas;
  logic [6:0]        hold_key;
  logic [VoiceW-1:0] hold_voice;
  logic              hold_has;
  logic              cmp_go;
  logic [VoiceW-1:0] rep;

  npva_list_ram u_ram (
    .clk    (clk),
    .we     (we),
    .wr     (wr),
    .raddr  (raddr),
    .rkey   (rkey),
    .rvoice (rvoice),
    .rhas   (rhas)
  );

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  // Shared compare unit: true while the search must move past this entry.
  always_comb begin
    if (pressed) begin
      case (mode)
        ModeLow:  cmp_go = key > rkey;
        ModeHigh: cmp_go = key < rkey;
        default:  cmp_go = 1'b0;
      endcase
    end else begin
      cmp_go = key != rkey;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_SEARCH;
      S_SEARCH: begin
        if (pressed && held_count == CntW'(MaxHeld)) state_next = S_SCAN_RD;
        else if (pressed && (mode == ModeFirst || mode > ModeHigh || idx >= held_count))
          state_next = S_SHIFT_RD;
        else if (idx >= held_count) state_next = S_REPORT;
        else state_next = S_SEARCH_WAIT;
      end
      S_SEARCH_WAIT: begin
        if (cmp_go) state_next = S_SEARCH;
        else state_next = S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        if (pressed) state_next = (idx > pos) ? S_SHIFT_WR : S_PLACE;
        else state_next = (idx + 1'b1 < held_count) ? S_SHIFT_WR : S_PLACE;
      end
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_PLACE: begin
        if (pressed) begin
          if (pos < CntW'(nv) && playing >= nv && CntW'(nv) <= n_old) state_next = S_STEAL_RD;
          else state_next = S_SCAN_RD;
        end else if (had && held_count >= CntW'(nv) && mode != ModeLast) begin
          state_next = S_HAND_RD;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_STEAL_RD: state_next = S_STEAL_WR;
      S_STEAL_WR: state_next = S_STEAL_CLR;
      S_STEAL_CLR: state_next = S_SCAN_RD;
      S_HAND_RD: state_next = S_HAND_WR;
      S_HAND_WR: state_next = S_SCAN_RD;
      S_SCAN_RD: state_next = (idx < held_count) ? S_SCAN_WR : S_FREE;
      S_SCAN_WR: state_next = S_SCAN_RD;
      S_FREE: state_next = S_REPORT;
      S_REPORT: if (VcntW'(rep) + 1'b1 == nv) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    raddr = idx[HeldAw-1:0];
    we = 1'b0;
    wr = '0;
    case (state)
      S_SHIFT_RD: if (!pressed) raddr = HeldAw'(idx + 1'b1);
                  else raddr = HeldAw'(idx - 1'b1);
      S_SHIFT_WR: begin
        we = 1'b1;
        wr.addr = idx[HeldAw-1:0];
        wr.key = rkey;
        wr.voice = rvoice;
        wr.has = rhas;
      end
      S_PLACE: begin
        we = pressed;
        wr.addr = pos[HeldAw-1:0];
        wr.key = key;
        wr.voice = new_voice;
        wr.has = new_has;
      end
      S_STEAL_RD: raddr = HeldAw'(nv);
      S_STEAL_WR: begin
        we = rhas;
        wr.addr = pos[HeldAw-1:0];
        wr.key = key;
        wr.voice = rvoice;
        wr.has = 1'b1;
      end
      S_STEAL_CLR: begin
        we = hold_has;
        wr.addr = HeldAw'(nv);
        wr.key = hold_key;
        wr.voice = hold_voice;
        wr.has = 1'b0;
      end
      S_HAND_RD: raddr = HeldAw'(nv - 1'b1);
      S_HAND_WR: begin
        we = !rhas;
        wr.addr = HeldAw'(nv - 1'b1);
        wr.key = rkey;
        wr.voice = fv;
        wr.has = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    new_has = 1'b0;
    new_voice = '0;
    if (pos < CntW'(nv) && playing < nv) begin
      new_has = 1'b1;
      new_voice = free_stack[VoiceW'(nv - playing - 1'b1)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= ModeLast;
      nv <= VcntW'(1);
      held_count <= '0;
      playing <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < MaxVoices; i++) begin
        free_stack[i] <= VoiceW'(i);
        voice_keys[i] <= '0;
        voice_gates[i] <= 1'b0;
      end
    end else begin
      state <= state_next;
      rsp_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == RegMode) begin
          mode <= cfg_data[2:0];
        end else begin
          if (cfg_data == 5'd0) nv <= VcntW'(1);
          else if (cfg_data > 5'(MaxVoices)) nv <= VcntW'(MaxVoices);
          else nv <= cfg_data[VcntW-1:0];
          held_count <= '0;
          playing <= '0;
          for (int i = 0; i < MaxVoices; i++) begin
            free_stack[i] <= VoiceW'(i);
            voice_gates[i] <= 1'b0;
          end
        end
      end
      case (state)
        S_IDLE: begin
          key <= req.key;
          pressed <= req.pressed;
          idx <= '0;
          dropped <= 1'b0;
          rep <= '0;
        end
        S_SEARCH: begin
          n_old <= held_count;
          if (pressed && held_count == CntW'(MaxHeld)) begin
            dropped <= 1'b1;
            idx <= '0;
          end else if (pressed && (mode == ModeFirst || mode > ModeHigh
                                   || idx >= held_count)) begin
            pos <= (mode == ModeFirst || idx >= held_count) ? held_count
                 : (mode > ModeHigh ? '0 : idx);
            idx <= held_count;
          end else if (idx >= held_count) begin
            rep <= '0;
          end
        end
        S_SEARCH_WAIT: begin
          if (cmp_go) begin
            idx <= idx + 1'b1;
          end else begin
            pos <= idx;
            had <= rhas;
            fv <= rvoice;
            if (pressed) idx <= held_count;
          end
        end
        S_SHIFT_RD: begin
          if (pressed) begin
            if (idx <= pos) held_count <= held_count + 1'b1;
          end else if (idx + 1'b1 >= held_count) begin
            held_count <= held_count - 1'b1;
          end
        end
        S_SHIFT_WR: idx <= pressed ? idx - 1'b1 : idx + 1'b1;
        S_PLACE: begin
          idx <= '0;
          if (pressed && new_has) playing <= playing + 1'b1;
          if (!pressed && had && !(held_count >= CntW'(nv) && mode != ModeLast)
              && playing != '0) begin
            free_stack[VoiceW'(nv - playing)] <= fv;
            playing <= playing - 1'b1;
          end
        end
        S_STEAL_WR: begin
          hold_key <= rkey;
          hold_voice <= rvoice;
          hold_has <= rhas;
        end
        S_HAND_WR: begin
          if (rhas && playing != '0) begin
            free_stack[VoiceW'(nv - playing)] <= fv;
            playing <= playing - 1'b1;
          end
        end
        S_SCAN_WR: begin
          if (rhas) begin
            voice_keys[rvoice] <= rkey;
            voice_gates[rvoice] <= 1'b1;
          end
          idx <= idx + 1'b1;
        end
        S_FREE: begin
          for (int i = 0; i < MaxVoices; i++) begin
            if (VcntW'(i) + playing < nv) voice_gates[free_stack[i]] <= 1'b0;
          end
          rep <= '0;
        end
        S_REPORT: begin
          rsp_valid <= 1'b1;
          rsp.voice <= 4'(rep);
          rsp.voice_key <= voice_keys[rep];
          rsp.gate <= voice_gates[rep];
          rsp.dropped <= dropped;
          rsp.last <= (VcntW'(rep) + 1'b1 == nv);
          rep <= rep + 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count: assert property (@(posedge clk) disable iff (rst)
    held_count <= CntW'(MaxHeld)) else $error("held count overflow");
  a_play: assert property (@(posedge clk) disable iff (rst)
    playing <= nv) else $error("playing count above voice count");
  a_rsp_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $past(busy)) else $error("result outside an event");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> !busy) else $error("config during event");
`endif

endmodule

[rtl/core/npva_list_ram.sv]
// Held list memory with one write port and one registered read port.
module npva_list_ram
  import npva_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  npva_wr_t          wr,
  input  logic [HeldAw-1:0] raddr,
  output logic [6:0]        rkey,
  output logic [VoiceW-1:0] rvoice,
  output logic              rhas
);

  logic [6:0]        mem_key [MaxHeld];
  logic [VoiceW-1:0] mem_voice [MaxHeld];
  logic              mem_has [MaxHeld];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_key[wr.addr] <= wr.key;
      mem_voice[wr.addr] <= wr.voice;
      mem_has[wr.addr] <= wr.has;
    end
    rkey <= mem_key[raddr];
    rvoice <= mem_voice[raddr];
    rhas <= mem_has[raddr];
  end

endmodule

[sim/tb_note_priority_voice_allocator_core.sv]
// Self-checking testbench of the note priority voice allocator core.
`timescale 1ns / 100ps

module tb_note_priority_voice_allocator_core
  import npva_pkg::*;
();

  localparam logic [2:0] ModeStack = 3'd4;
  localparam logic [2:0] ModeUnknown = 3'd7;
  localparam int IdleLimit = 20000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  npva_in_t  req = '0;
  logic      rsp_valid;
  npva_out_t rsp;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_index = 1'b0;
  logic [4:0] cfg_data = '0;

  logic [2:0] mode;
  int         voices;
  logic [6:0] held_key[MaxHeld];
  logic [3:0] held_voice[MaxHeld];
  logic       held_has[MaxHeld];
  int         held_n;
  logic [3:0] free_stack[MaxVoices];
  int         playing;
  logic [6:0] voice_key[MaxVoices];
  logic       voice_gate[MaxVoices];

  npva_out_t  voice_reports[$];
  int         errors = 0;
  int         idle_cycles = 0;

  note_priority_voice_allocator_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .rsp_valid(rsp_valid), .rsp(rsp), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void restart_alloc();
    held_n = 0;
    playing = 0;
    for (int i = 0; i < MaxVoices; i++) begin
      free_stack[i] = i[3:0];
      voice_gate[i] = 1'b0;
    end
  endfunction

  function automatic void press_key(logic [6:0] k);
    int ins;
    ins = 0;
    if (mode == ModeLow) begin
      while (ins < held_n && k > held_key[ins]) ins++;
    end else if (mode == ModeHigh) begin
      while (ins < held_n && k < held_key[ins]) ins++;
    end else if (mode == ModeFirst) begin
      ins = held_n;
    end
    for (int j = held_n; j > ins; j--) begin
      held_key[j] = held_key[j-1];
      held_voice[j] = held_voice[j-1];
      held_has[j] = held_has[j-1];
    end
    held_key[ins] = k;
    held_has[ins] = 1'b0;
    held_voice[ins] = '0;
    if (ins < voices) begin
      if (playing < voices) begin
        held_voice[ins] = free_stack[voices - playing - 1];
        held_has[ins] = 1'b1;
        playing++;
      end else if (voices <= held_n && held_has[voices]) begin
        held_voice[ins] = held_voice[voices];
        held_has[ins] = 1'b1;
        held_has[voices] = 1'b0;
      end
    end
    held_n++;
  endfunction

  function automatic void release_key(logic [6:0] k);
    int del;
    logic had;
    logic [3:0] fv;
    del = 0;
    while (del < held_n && k != held_key[del]) del++;
    if (del >= held_n) return;
    had = held_has[del];
    fv = held_voice[del];
    for (int j = del; j + 1 < held_n; j++) begin
      held_key[j] = held_key[j+1];
      held_voice[j] = held_voice[j+1];
      held_has[j] = held_has[j+1];
    end
    held_n--;
    if (!had) return;
    if (held_n >= voices && mode != ModeLast && !held_has[voices-1]) begin
      held_voice[voices-1] = fv;
      held_has[voices-1] = 1'b1;
    end else if (playing > 0) begin
      free_stack[voices - playing] = fv;
      playing--;
    end
  endfunction

  function automatic void predict_voices(npva_in_t it);
    logic drop;
    npva_out_t r;
    drop = 1'b0;
    if (it.pressed) begin
      if (held_n >= MaxHeld) drop = 1'b1;
      else press_key(it.key);
    end else begin
      release_key(it.key);
    end
    for (int i = 0; i < held_n; i++) begin
      if (held_has[i]) begin
        voice_key[held_voice[i]] = held_key[i];
        voice_gate[held_voice[i]] = 1'b1;
      end
    end
    for (int i = 0; i + playing < voices; i++) voice_gate[free_stack[i]] = 1'b0;
    for (int i = 0; i < voices; i++) begin
      r.voice = i[3:0];
      r.voice_key = voice_key[i];
      r.gate = voice_gate[i];
      r.dropped = drop;
      r.last = (i + 1 == voices);
      voice_reports.push_back(r);
    end
  endfunction

  task automatic send_event(logic [6:0] k, logic p);
    int gap;
    npva_in_t it;
    gap = $urandom_range(0, 15);
    it.key = k;
    it.pressed = p;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_voices(it);
  endtask

  task automatic write_reg(logic idx, logic [4:0] data);
    int v;
    start <= 1'b0;
    @(posedge clk);
    while (voice_reports.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == RegMode) begin
      mode = data[2:0];
    end else begin
      v = data;
      if (v < 1) v = 1;
      if (v > MaxVoices) v = MaxVoices;
      voices = v;
      restart_alloc();
    end
  endtask

  task automatic test_priority_modes();
    write_reg(RegVoices, 5'd2);
    write_reg(RegMode, 5'(ModeLow));
    send_event(7'd60, 1'b1);
    send_event(7'd40, 1'b1);
    send_event(7'd0, 1'b1);
    send_event(7'd127, 1'b1);
    send_event(7'd0, 1'b0);
    send_event(7'd99, 1'b0);
    send_event(7'd60, 1'b1);
    send_event(7'd60, 1'b0);
    write_reg(RegMode, 5'(ModeHigh));
    send_event(7'd100, 1'b1);
    send_event(7'd100, 1'b0);
    write_reg(RegMode, 5'(ModeLast));
    send_event(7'd50, 1'b1);
    send_event(7'd50, 1'b0);
    write_reg(RegMode, 5'(ModeFirst));
    send_event(7'd70, 1'b1);
    send_event(7'd40, 1'b0);
    write_reg(RegMode, 5'(ModeStack));
    send_event(7'd85, 1'b1);
    send_event(7'd85, 1'b0);
    write_reg(RegMode, 5'(ModeUnknown));
    send_event(7'd21, 1'b1);
    send_event(7'd21, 1'b0);
  endtask

  task automatic test_voice_count_limits();
    write_reg(RegVoices, 5'd0);
    send_event(7'd64, 1'b1);
    send_event(7'd65, 1'b1);
    write_reg(RegVoices, 5'd31);
    send_event(7'd66, 1'b1);
    send_event(7'd66, 1'b0);
  endtask

  task automatic test_full_list();
    write_reg(RegVoices, 5'd16);
    write_reg(RegMode, 5'(ModeFirst));
    for (int i = 0; i < MaxHeld + 2; i++) send_event(7'($urandom_range(0, 127)), 1'b1);
    send_event(held_key[$urandom_range(0, held_n - 1)], 1'b0);
    send_event(7'd5, 1'b1);
  endtask

  task automatic test_random_play();
    int pick;
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(RegMode, 5'($urandom_range(0, 7)));
      if (ph == 0) write_reg(RegVoices, 5'd1);
      else if (ph == 1) write_reg(RegVoices, 5'd16);
      else write_reg(RegVoices, 5'($urandom_range(0, 31)));
      for (int i = 0; i < 10; i++) begin
        pick = $urandom_range(0, 99);
        if (ph > 1 && i == 5) write_reg(RegMode, 5'($urandom_range(0, 7)));
        if (pick < 55 || held_n == 0) begin
          send_event(pick < 20 ? 7'($urandom_range(58, 62)) : 7'($urandom_range(0, 127)),
                     1'b1);
        end else if (pick < 94) begin
          send_event(held_key[$urandom_range(0, held_n - 1)], 1'b0);
        end else begin
          send_event(7'($urandom_range(0, 127)), 1'b0);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid) begin
      if (voice_reports.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", rsp);
      end else begin
        if (rsp !== voice_reports[0]) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch voice %0d: expected key %0d gate %b drop %b last %b, ",
                      "got %0d key %0d gate %b drop %b last %b"},
                     voice_reports[0].voice, voice_reports[0].voice_key,
                     voice_reports[0].gate, voice_reports[0].dropped,
                     voice_reports[0].last, rsp.voice, rsp.voice_key,
                     rsp.gate, rsp.dropped, rsp.last);
        end
        void'(voice_reports.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || rsp_valid || (cfg_valid && cfg_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_note_priority_voice_allocator_core NOT OK");
      $finish;
    end
  end

  initial begin
    mode = ModeLast;
    voices = 1;
    for (int i = 0; i < MaxVoices; i++) voice_key[i] = '0;
    restart_alloc();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_priority_modes();
    test_voice_count_limits();
    test_full_list();
    test_random_play();
    start <= 1'b0;
    @(posedge clk);
    while (voice_reports.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && voice_reports.size() == 0) begin
      $display("tb_note_priority_voice_allocator_core OK");
    end else begin
      $display("tb_note_priority_voice_allocator_core NOT OK");
    end
    $finish;
  end

endmodule
